// File: sv/rv32enc_pkg.sv
// Package for the RV32IM instruction encoder: payload structs, opcodes,
// fixed machine words and mnemonic codes. No dependencies.
package rv32enc_pkg;

   typedef struct packed {
      logic [5:0]         req_type;
      logic signed [31:0] arg_one;
      logic signed [31:0] arg_two;
      logic signed [31:0] arg_three;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] machine_word;
      logic        recognized;
   } rsp_payload_type;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MUL  = 7'h01;

   localparam logic [31:0] WORD_MRET  = 32'h3020_0073;
   localparam logic [31:0] WORD_SRET  = 32'h1020_0073;
   localparam logic [31:0] WORD_WFI   = 32'h1050_0073;
   localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
   localparam logic [31:0] WORD_EBRK  = 32'h0010_0073;

   localparam logic [5:0] CODE_ADD    = 6'd0;
   localparam logic [5:0] CODE_SUB    = 6'd1;
   localparam logic [5:0] CODE_SLL    = 6'd2;
   localparam logic [5:0] CODE_SLT    = 6'd3;
   localparam logic [5:0] CODE_SLTU   = 6'd4;
   localparam logic [5:0] CODE_XOR    = 6'd5;
   localparam logic [5:0] CODE_SRL    = 6'd6;
   localparam logic [5:0] CODE_SRA    = 6'd7;
   localparam logic [5:0] CODE_OR     = 6'd8;
   localparam logic [5:0] CODE_AND    = 6'd9;
   localparam logic [5:0] CODE_MUL    = 6'd10;
   localparam logic [5:0] CODE_DIV    = 6'd11;
   localparam logic [5:0] CODE_DIVU   = 6'd12;
   localparam logic [5:0] CODE_REM    = 6'd13;
   localparam logic [5:0] CODE_REMU   = 6'd14;
   localparam logic [5:0] CODE_ADDI   = 6'd15;
   localparam logic [5:0] CODE_SLTI   = 6'd16;
   localparam logic [5:0] CODE_SLTIU  = 6'd17;
   localparam logic [5:0] CODE_XORI   = 6'd18;
   localparam logic [5:0] CODE_ORI    = 6'd19;
   localparam logic [5:0] CODE_ANDI   = 6'd20;
   localparam logic [5:0] CODE_SLLI   = 6'd21;
   localparam logic [5:0] CODE_SRLI   = 6'd22;
   localparam logic [5:0] CODE_SRAI   = 6'd23;
   localparam logic [5:0] CODE_LB     = 6'd24;
   localparam logic [5:0] CODE_LH     = 6'd25;
   localparam logic [5:0] CODE_LW     = 6'd26;
   localparam logic [5:0] CODE_LBU    = 6'd27;
   localparam logic [5:0] CODE_LHU    = 6'd28;
   localparam logic [5:0] CODE_CSRRW  = 6'd29;
   localparam logic [5:0] CODE_CSRRS  = 6'd30;
   localparam logic [5:0] CODE_CSRRC  = 6'd31;
   localparam logic [5:0] CODE_CSRR   = 6'd32;
   localparam logic [5:0] CODE_CSRW   = 6'd33;
   localparam logic [5:0] CODE_CSRC   = 6'd34;
   localparam logic [5:0] CODE_CSRS   = 6'd35;
   localparam logic [5:0] CODE_SB     = 6'd36;
   localparam logic [5:0] CODE_SH     = 6'd37;
   localparam logic [5:0] CODE_SW     = 6'd38;
   localparam logic [5:0] CODE_BEQ    = 6'd39;
   localparam logic [5:0] CODE_BNE    = 6'd40;
   localparam logic [5:0] CODE_BLT    = 6'd41;
   localparam logic [5:0] CODE_BGE    = 6'd42;
   localparam logic [5:0] CODE_BLTU   = 6'd43;
   localparam logic [5:0] CODE_BGEU   = 6'd44;
   localparam logic [5:0] CODE_BEQZ   = 6'd45;
   localparam logic [5:0] CODE_BNEZ   = 6'd46;
   localparam logic [5:0] CODE_JAL    = 6'd47;
   localparam logic [5:0] CODE_JALR   = 6'd48;
   localparam logic [5:0] CODE_LUI    = 6'd49;
   localparam logic [5:0] CODE_AUIPC  = 6'd50;
   localparam logic [5:0] CODE_ECALL  = 6'd51;
   localparam logic [5:0] CODE_EBREAK = 6'd52;
   localparam logic [5:0] CODE_LI     = 6'd53;
   localparam logic [5:0] CODE_MV     = 6'd54;
   localparam logic [5:0] CODE_J      = 6'd55;
   localparam logic [5:0] CODE_RET    = 6'd56;
   localparam logic [5:0] CODE_NOP    = 6'd57;
   localparam logic [5:0] CODE_MRET   = 6'd58;
   localparam logic [5:0] CODE_SRET   = 6'd59;
   localparam logic [5:0] CODE_WFI    = 6'd60;

endpackage

// File: sv/rv32enc_encode.sv
// Combinational RV32IM encoder: mnemonic code and operands to machine word.
// Depends on rv32enc_pkg.
module rv32enc_encode (
   input  rv32enc_pkg::req_payload_type req_data,
   output rv32enc_pkg::rsp_payload_type rsp_data
);

   function automatic logic [31:0] pack_r(input logic [2:0] f3, input logic [6:0] f7,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [4:0] rd);
      pack_r = {f7, rs2, rs1, f3, rd, rv32enc_pkg::OPC_OP};
   endfunction

   function automatic logic [31:0] pack_i(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [4:0] rd);
      pack_i = {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] pack_s(input logic [2:0] f3, input logic [4:0] rs2,
                                          input logic [11:0] imm, input logic [4:0] rs1);
      pack_s = {imm[11:5], rs2, rs1, f3, imm[4:0], rv32enc_pkg::OPC_STORE};
   endfunction

   function automatic logic [31:0] pack_b(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [12:0] off);
      pack_b = {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11],
                rv32enc_pkg::OPC_BRANCH};
   endfunction

   function automatic logic [31:0] pack_j(input logic [4:0] rd, input logic [20:0] off);
      pack_j = {off[20], off[10:1], off[11], off[19:12], rd, rv32enc_pkg::OPC_JAL};
   endfunction

   function automatic logic [31:0] pack_u(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [31:0] val);
      pack_u = {val[31:12], rd, op};
   endfunction

   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] c;
   logic [31:0] word;
   logic        known;

   assign a = req_data.arg_one;
   assign b = req_data.arg_two;
   assign c = req_data.arg_three;

   always_comb begin
      word  = '0;
      known = 1'b1;
      unique case (req_data.req_type)
         rv32enc_pkg::CODE_ADD:    word = pack_r(3'd0, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SUB:    word = pack_r(3'd0, rv32enc_pkg::F7_ALT, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLL:    word = pack_r(3'd1, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLT:    word = pack_r(3'd2, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLTU:   word = pack_r(3'd3, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_XOR:    word = pack_r(3'd4, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SRL:    word = pack_r(3'd5, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_SRA:    word = pack_r(3'd5, rv32enc_pkg::F7_ALT, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_OR:     word = pack_r(3'd6, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_AND:    word = pack_r(3'd7, rv32enc_pkg::F7_BASE, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_MUL:    word = pack_r(3'd0, rv32enc_pkg::F7_MUL, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_DIV:    word = pack_r(3'd4, rv32enc_pkg::F7_MUL, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_DIVU:   word = pack_r(3'd5, rv32enc_pkg::F7_MUL, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_REM:    word = pack_r(3'd6, rv32enc_pkg::F7_MUL, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_REMU:   word = pack_r(3'd7, rv32enc_pkg::F7_MUL, b[4:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_ADDI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd0, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLTI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd2, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLTIU:  word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd3, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_XORI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd4, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_ORI:    word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd6, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_ANDI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd7, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_SLLI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd1,
                                                 {rv32enc_pkg::F7_BASE, c[4:0]}, b[4:0], a[4:0]);
         rv32enc_pkg::CODE_SRLI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd5,
                                                 {rv32enc_pkg::F7_BASE, c[4:0]}, b[4:0], a[4:0]);
         rv32enc_pkg::CODE_SRAI:   word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd5,
                                                 {rv32enc_pkg::F7_ALT, c[4:0]}, b[4:0], a[4:0]);
         rv32enc_pkg::CODE_LB:     word = pack_i(rv32enc_pkg::OPC_LOAD, 3'd0, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_LH:     word = pack_i(rv32enc_pkg::OPC_LOAD, 3'd1, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_LW:     word = pack_i(rv32enc_pkg::OPC_LOAD, 3'd2, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_LBU:    word = pack_i(rv32enc_pkg::OPC_LOAD, 3'd4, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_LHU:    word = pack_i(rv32enc_pkg::OPC_LOAD, 3'd5, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_CSRRW:  word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd1, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_CSRRS:  word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd2, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_CSRRC:  word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd3, b[11:0], c[4:0], a[4:0]);
         rv32enc_pkg::CODE_CSRR:   word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd2, b[11:0], 5'd0, a[4:0]);
         rv32enc_pkg::CODE_CSRW:   word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd1, a[11:0], b[4:0], 5'd0);
         rv32enc_pkg::CODE_CSRC:   word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd3, a[11:0], b[4:0], 5'd0);
         rv32enc_pkg::CODE_CSRS:   word = pack_i(rv32enc_pkg::OPC_SYSTEM, 3'd2, a[11:0], b[4:0], 5'd0);
         rv32enc_pkg::CODE_SB:     word = pack_s(3'd0, a[4:0], b[11:0], c[4:0]);
         rv32enc_pkg::CODE_SH:     word = pack_s(3'd1, a[4:0], b[11:0], c[4:0]);
         rv32enc_pkg::CODE_SW:     word = pack_s(3'd2, a[4:0], b[11:0], c[4:0]);
         rv32enc_pkg::CODE_BEQ:    word = pack_b(3'd0, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BNE:    word = pack_b(3'd1, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BLT:    word = pack_b(3'd4, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BGE:    word = pack_b(3'd5, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BLTU:   word = pack_b(3'd6, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BGEU:   word = pack_b(3'd7, a[4:0], b[4:0], c[12:0]);
         rv32enc_pkg::CODE_BEQZ:   word = pack_b(3'd0, a[4:0], 5'd0, c[12:0]);
         rv32enc_pkg::CODE_BNEZ:   word = pack_b(3'd1, a[4:0], 5'd0, c[12:0]);
         rv32enc_pkg::CODE_JAL:    word = pack_j(a[4:0], b[20:0]);
         rv32enc_pkg::CODE_JALR:   word = pack_i(rv32enc_pkg::OPC_JALR, 3'd0, c[11:0], b[4:0], a[4:0]);
         rv32enc_pkg::CODE_LUI:    word = pack_u(rv32enc_pkg::OPC_LUI, a[4:0], b);
         rv32enc_pkg::CODE_AUIPC:  word = pack_u(rv32enc_pkg::OPC_AUIPC, a[4:0], b);
         rv32enc_pkg::CODE_ECALL:  word = rv32enc_pkg::WORD_ECALL;
         rv32enc_pkg::CODE_EBREAK: word = rv32enc_pkg::WORD_EBRK;
         rv32enc_pkg::CODE_LI:     word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd0, b[11:0], 5'd0, a[4:0]);
         rv32enc_pkg::CODE_MV:     word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd0, 12'd0, b[4:0], a[4:0]);
         rv32enc_pkg::CODE_J:      word = pack_j(5'd0, b[20:0]);
         rv32enc_pkg::CODE_RET:    word = pack_i(rv32enc_pkg::OPC_JALR, 3'd0, 12'd0, 5'd1, 5'd0);
         rv32enc_pkg::CODE_NOP:    word = pack_i(rv32enc_pkg::OPC_OPIMM, 3'd0, 12'd0, 5'd0, 5'd0);
         rv32enc_pkg::CODE_MRET:   word = rv32enc_pkg::WORD_MRET;
         rv32enc_pkg::CODE_SRET:   word = rv32enc_pkg::WORD_SRET;
         rv32enc_pkg::CODE_WFI:    word = rv32enc_pkg::WORD_WFI;
         default: begin
            word  = '0;
            known = 1'b0;
         end
      endcase
   end

   assign rsp_data.machine_word = word;
   assign rsp_data.recognized   = known;

endmodule

// File: sv/rv32im_instruction_encoder.sv
// RV32IM instruction encoder top level: input register, encoder, result register.
// Depends on rv32enc_pkg and rv32enc_encode.
// Flow: a request is captured in the input register, encoded, and then captured in the
// result register, whose valid flag drives rsp_valid; a stall on rsp_ready can hold it.
// Throughput: one instruction per cycle; req_ready falls only while both registers
// hold an item and rsp_ready is low.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
module rv32im_instruction_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rv32enc_pkg::req_payload_type  req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rv32enc_pkg::rsp_payload_type  rsp_data
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   rv32enc_pkg::req_payload_type s1_data_ff;
   logic                         s2_valid_ff;
   logic                         s2_valid_in;
   rv32enc_pkg::rsp_payload_type s2_data_ff;
   rv32enc_pkg::rsp_payload_type enc_data;
   logic                         s1_free;
   logic                         s2_free;

   rv32enc_encode u_encode (
      .req_data (s1_data_ff),
      .rsp_data (enc_data)
   );

   assign s2_free     = !s2_valid_ff || rsp_ready;
   assign s1_free     = !s1_valid_ff || s2_free;
   assign s1_valid_in = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_data_ff <= req_data;
      end
      if (s1_valid_ff && s2_free) begin
         s2_data_ff <= enc_data;
      end
   end

   assign req_ready = s1_free;
   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

endmodule

// File: bench/rv32im_instruction_encoder_test.sv
// Self-checking bench for rv32im_instruction_encoder: directed table, a sweep of all codes,
// then random instructions under random sender bursts and receiver stalls.
// Depends on rv32enc_pkg and the encoder RTL only.
module rv32im_instruction_encoder_test;

   localparam int          SWEEP_TOP    = 63;
   localparam int          RANDOM_COUNT = 1500;
   localparam int          LONG_HOLD    = 60;
   localparam int          HOLD_AFTER   = 300;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [31:0] SRAI_FLAG    = 32'h0000_0400;
   localparam logic [31:0] REG_ZERO     = 32'd0;
   localparam logic [31:0] REG_RA       = 32'd1;
   localparam logic [31:0] IMM_ZERO     = 32'd0;
   localparam logic [5:0]  CODE_UNKNOWN_FIRST = rv32enc_pkg::CODE_WFI + 6'd1;
   localparam logic [5:0]  CODE_UNKNOWN_LAST  = 6'(SWEEP_TOP);

   typedef struct packed {
      rv32enc_pkg::req_payload_type instr;
      logic                         fixed;
      rv32enc_pkg::rsp_payload_type word;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   rv32enc_pkg::req_payload_type req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   rv32enc_pkg::rsp_payload_type rsp_data;

   rv32enc_pkg::rsp_payload_type pending_words[$];
   plan_row_type                 plan[$];
   int                           failures = 0;
   int                           accepted_reqs = 0;
   int                           burst_left = 0;
   bit                           long_hold_done = 1'b0;

   rv32im_instruction_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] r_word(logic [2:0] f3, logic [6:0] f7,
                                          logic [31:0] rd, logic [31:0] rs1, logic [31:0] rs2);
      return {f7, rs2[4:0], rs1[4:0], f3, rd[4:0], rv32enc_pkg::OPC_OP};
   endfunction

   function automatic logic [31:0] i_word(logic [6:0] opc, logic [2:0] f3,
                                          logic [31:0] rd, logic [31:0] rs1, logic [31:0] imm);
      return {imm[11:0], rs1[4:0], f3, rd[4:0], opc};
   endfunction

   function automatic logic [31:0] s_word(logic [2:0] f3, logic [31:0] rs2, logic [31:0] rs1,
                                          logic [31:0] imm);
      return {imm[11:5], rs2[4:0], rs1[4:0], f3, imm[4:0], rv32enc_pkg::OPC_STORE};
   endfunction

   function automatic logic [31:0] b_word(logic [2:0] f3, logic [31:0] rs1, logic [31:0] rs2,
                                          logic [31:0] off);
      return {off[12], off[10:5], rs2[4:0], rs1[4:0], f3, off[4:1], off[11],
              rv32enc_pkg::OPC_BRANCH};
   endfunction

   function automatic logic [31:0] j_word(logic [31:0] rd, logic [31:0] off);
      return {off[20], off[10:1], off[11], off[19:12], rd[4:0], rv32enc_pkg::OPC_JAL};
   endfunction

   function automatic logic [31:0] u_word(logic [6:0] opc, logic [31:0] rd, logic [31:0] val);
      return {val[31:12], rd[4:0], opc};
   endfunction

   function automatic rv32enc_pkg::rsp_payload_type encode_instr(
      rv32enc_pkg::req_payload_type instr);
      rv32enc_pkg::rsp_payload_type res;
      logic [31:0]                  a, b, c, shamt, w;
      a = instr.arg_one;
      b = instr.arg_two;
      c = instr.arg_three;
      shamt = {27'd0, c[4:0]};
      w = '0;
      res.recognized = 1'b1;
      case (instr.req_type)
         rv32enc_pkg::CODE_ADD:    w = r_word(3'd0, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_SUB:    w = r_word(3'd0, rv32enc_pkg::F7_ALT, a, b, c);
         rv32enc_pkg::CODE_SLL:    w = r_word(3'd1, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_SLT:    w = r_word(3'd2, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_SLTU:   w = r_word(3'd3, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_XOR:    w = r_word(3'd4, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_SRL:    w = r_word(3'd5, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_SRA:    w = r_word(3'd5, rv32enc_pkg::F7_ALT, a, b, c);
         rv32enc_pkg::CODE_OR:     w = r_word(3'd6, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_AND:    w = r_word(3'd7, rv32enc_pkg::F7_BASE, a, b, c);
         rv32enc_pkg::CODE_MUL:    w = r_word(3'd0, rv32enc_pkg::F7_MUL, a, b, c);
         rv32enc_pkg::CODE_DIV:    w = r_word(3'd4, rv32enc_pkg::F7_MUL, a, b, c);
         rv32enc_pkg::CODE_DIVU:   w = r_word(3'd5, rv32enc_pkg::F7_MUL, a, b, c);
         rv32enc_pkg::CODE_REM:    w = r_word(3'd6, rv32enc_pkg::F7_MUL, a, b, c);
         rv32enc_pkg::CODE_REMU:   w = r_word(3'd7, rv32enc_pkg::F7_MUL, a, b, c);
         rv32enc_pkg::CODE_ADDI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd0, a, b, c);
         rv32enc_pkg::CODE_SLTI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd2, a, b, c);
         rv32enc_pkg::CODE_SLTIU:  w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd3, a, b, c);
         rv32enc_pkg::CODE_XORI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd4, a, b, c);
         rv32enc_pkg::CODE_ORI:    w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd6, a, b, c);
         rv32enc_pkg::CODE_ANDI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd7, a, b, c);
         rv32enc_pkg::CODE_SLLI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd1, a, b, shamt);
         rv32enc_pkg::CODE_SRLI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd5, a, b, shamt);
         rv32enc_pkg::CODE_SRAI:   w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd5, a, b,
                                              shamt | SRAI_FLAG);
         rv32enc_pkg::CODE_LB:     w = i_word(rv32enc_pkg::OPC_LOAD, 3'd0, a, c, b);
         rv32enc_pkg::CODE_LH:     w = i_word(rv32enc_pkg::OPC_LOAD, 3'd1, a, c, b);
         rv32enc_pkg::CODE_LW:     w = i_word(rv32enc_pkg::OPC_LOAD, 3'd2, a, c, b);
         rv32enc_pkg::CODE_LBU:    w = i_word(rv32enc_pkg::OPC_LOAD, 3'd4, a, c, b);
         rv32enc_pkg::CODE_LHU:    w = i_word(rv32enc_pkg::OPC_LOAD, 3'd5, a, c, b);
         rv32enc_pkg::CODE_CSRRW:  w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd1, a, c, b);
         rv32enc_pkg::CODE_CSRRS:  w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd2, a, c, b);
         rv32enc_pkg::CODE_CSRRC:  w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd3, a, c, b);
         rv32enc_pkg::CODE_CSRR:   w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd2, a, REG_ZERO, b);
         rv32enc_pkg::CODE_CSRW:   w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd1, REG_ZERO, b, a);
         rv32enc_pkg::CODE_CSRC:   w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd3, REG_ZERO, b, a);
         rv32enc_pkg::CODE_CSRS:   w = i_word(rv32enc_pkg::OPC_SYSTEM, 3'd2, REG_ZERO, b, a);
         rv32enc_pkg::CODE_SB:     w = s_word(3'd0, a, c, b);
         rv32enc_pkg::CODE_SH:     w = s_word(3'd1, a, c, b);
         rv32enc_pkg::CODE_SW:     w = s_word(3'd2, a, c, b);
         rv32enc_pkg::CODE_BEQ:    w = b_word(3'd0, a, b, c);
         rv32enc_pkg::CODE_BNE:    w = b_word(3'd1, a, b, c);
         rv32enc_pkg::CODE_BLT:    w = b_word(3'd4, a, b, c);
         rv32enc_pkg::CODE_BGE:    w = b_word(3'd5, a, b, c);
         rv32enc_pkg::CODE_BLTU:   w = b_word(3'd6, a, b, c);
         rv32enc_pkg::CODE_BGEU:   w = b_word(3'd7, a, b, c);
         rv32enc_pkg::CODE_BEQZ:   w = b_word(3'd0, a, REG_ZERO, c);
         rv32enc_pkg::CODE_BNEZ:   w = b_word(3'd1, a, REG_ZERO, c);
         rv32enc_pkg::CODE_JAL:    w = j_word(a, b);
         rv32enc_pkg::CODE_JALR:   w = i_word(rv32enc_pkg::OPC_JALR, 3'd0, a, b, c);
         rv32enc_pkg::CODE_LUI:    w = u_word(rv32enc_pkg::OPC_LUI, a, b);
         rv32enc_pkg::CODE_AUIPC:  w = u_word(rv32enc_pkg::OPC_AUIPC, a, b);
         rv32enc_pkg::CODE_ECALL:  w = rv32enc_pkg::WORD_ECALL;
         rv32enc_pkg::CODE_EBREAK: w = rv32enc_pkg::WORD_EBRK;
         rv32enc_pkg::CODE_LI:     w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd0, a, REG_ZERO, b);
         rv32enc_pkg::CODE_MV:     w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd0, a, b, IMM_ZERO);
         rv32enc_pkg::CODE_J:      w = j_word(REG_ZERO, b);
         rv32enc_pkg::CODE_RET:    w = i_word(rv32enc_pkg::OPC_JALR, 3'd0, REG_ZERO, REG_RA,
                                              IMM_ZERO);
         rv32enc_pkg::CODE_NOP:    w = i_word(rv32enc_pkg::OPC_OPIMM, 3'd0, REG_ZERO, REG_ZERO,
                                              IMM_ZERO);
         rv32enc_pkg::CODE_MRET:   w = rv32enc_pkg::WORD_MRET;
         rv32enc_pkg::CODE_SRET:   w = rv32enc_pkg::WORD_SRET;
         rv32enc_pkg::CODE_WFI:    w = rv32enc_pkg::WORD_WFI;
         default: begin
            w = '0;
            res.recognized = 1'b0;
         end
      endcase
      res.machine_word = w;
      return res;
   endfunction

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 31);
         2: v = {{20{1'b0}}, 12'($urandom)} - (($urandom_range(0, 1) != 0) ? 32'h1000 : 32'h0);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h0000_0000;
               1: v = 32'hFFFF_FFFF;
               2: v = 32'h8000_0000;
               default: v = 32'h7FFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic rv32enc_pkg::req_payload_type random_instr();
      rv32enc_pkg::req_payload_type instr;
      if ($urandom_range(0, 15) == 0)
         instr.req_type = 6'($urandom_range(int'(CODE_UNKNOWN_FIRST), SWEEP_TOP));
      else
         instr.req_type = 6'($urandom_range(0, int'(rv32enc_pkg::CODE_WFI)));
      instr.arg_one = random_operand();
      instr.arg_two = random_operand();
      instr.arg_three = random_operand();
      return instr;
   endfunction

   task automatic add_row(logic [5:0] code, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic fixed = 1'b0, logic [31:0] word = '0, logic recog = 1'b1);
      plan_row_type row;
      row.instr = {code, a, b, c};
      row.fixed = fixed;
      row.word = {word, recog};
      plan.push_back(row);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_instr(rv32enc_pkg::req_payload_type instr, logic fixed,
                             rv32enc_pkg::rsp_payload_type word);
      req_valid <= 1'b1;
      req_data <= instr;
      do @(posedge clock); while (!req_ready);
      accepted_reqs++;
      pending_words.push_back(fixed ? word : encode_instr(instr));
   endtask

   always @(posedge clock) begin
      rv32enc_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected transfer expected none actual %h/%b", $time,
                     rsp_data.machine_word, rsp_data.recognized);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.machine_word !== want.machine_word) begin
               $display("%0t: machine_word expected %h actual %h", $time,
                        want.machine_word, rsp_data.machine_word);
               failures++;
            end
            if (rsp_data.recognized !== want.recognized) begin
               $display("%0t: recognized expected %b actual %b", $time,
                        want.recognized, rsp_data.recognized);
               failures++;
            end
         end
      end
   end

   initial begin : receiver
      int mode;
      int stretch;
      wait (!reset);
      forever begin
         if (!long_hold_done && accepted_reqs >= HOLD_AFTER) begin
            // hold off long enough for the block to fill and stall the sender
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(1, 30);
            repeat (stretch) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 1) != 0);
                  default: rsp_ready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      rv32enc_pkg::req_payload_type instr;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_row(rv32enc_pkg::CODE_ADD, 32'h0, 32'h0, 32'h0, 1'b1, {25'd0, rv32enc_pkg::OPC_OP});
      add_row(rv32enc_pkg::CODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_SRAI, 32'h8000_0001, 32'h7FFF_FFE2, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_SLLI, 32'd31, 32'd31, 32'h7FFF_FFE0);
      add_row(rv32enc_pkg::CODE_ADDI, 32'd1, 32'd2, 32'h7FFF_FFFF);
      add_row(rv32enc_pkg::CODE_ADDI, 32'd1, 32'd2, 32'h8000_0000);
      add_row(rv32enc_pkg::CODE_LW, 32'd5, 32'hFFFF_F800, 32'd6);
      add_row(rv32enc_pkg::CODE_SW, 32'd7, 32'd2047, 32'hFFFF_FFE8);
      add_row(rv32enc_pkg::CODE_BEQ, 32'd1, 32'd2, 32'hFFFF_F000);
      add_row(rv32enc_pkg::CODE_BNE, 32'd1, 32'd2, 32'd4094);
      add_row(rv32enc_pkg::CODE_BGEU, 32'd30, 32'd31, 32'd1);
      add_row(rv32enc_pkg::CODE_BNEZ, 32'd3, 32'h5555_5555, 32'hFFFF_F001);
      add_row(rv32enc_pkg::CODE_JAL, 32'd1, 32'h000F_FFFE, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_J, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_LUI, 32'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_AUIPC, 32'd0, 32'h0000_0FFF, 32'd0, 1'b1,
              {25'd0, rv32enc_pkg::OPC_AUIPC});
      add_row(rv32enc_pkg::CODE_CSRRW, 32'h8000_0001, 32'hFFFF_F300, 32'd31);
      add_row(rv32enc_pkg::CODE_CSRW, 32'hFFFF_F341, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(rv32enc_pkg::CODE_ECALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              rv32enc_pkg::WORD_ECALL);
      add_row(rv32enc_pkg::CODE_EBREAK, 32'h0, 32'h0, 32'h0, 1'b1, rv32enc_pkg::WORD_EBRK);
      add_row(rv32enc_pkg::CODE_MRET, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1,
              rv32enc_pkg::WORD_MRET);
      add_row(rv32enc_pkg::CODE_SRET, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1,
              rv32enc_pkg::WORD_SRET);
      add_row(rv32enc_pkg::CODE_WFI, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
              rv32enc_pkg::WORD_WFI);
      add_row(rv32enc_pkg::CODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              {25'd0, rv32enc_pkg::OPC_OPIMM});
      add_row(rv32enc_pkg::CODE_RET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              32'h0000_8067);
      add_row(CODE_UNKNOWN_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              32'h0, 1'b0);
      add_row(CODE_UNKNOWN_LAST, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0);

      foreach (plan[i]) begin
         pace_sender();
         send_instr(plan[i].instr, plan[i].fixed, plan[i].word);
      end

      for (int code = 0; code <= SWEEP_TOP; code++) begin
         instr = random_instr();
         instr.req_type = 6'(code);
         pace_sender();
         send_instr(instr, 1'b0, '0);
      end

      repeat (RANDOM_COUNT) begin
         pace_sender();
         send_instr(random_instr(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
